### hw/rtl/cst_pkg.sv
// Shared types and constants for the connection slot table.
package cst_pkg;

    localparam int KEY_W       = 32;
    localparam int FLAG_W      = 8;
    localparam int NETID_W     = 32;
    localparam int PLAYER_W    = 4;
    localparam int SLOT_OUT_W  = 4;
    localparam int COUNT_OUT_W = 5;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_SYN_MASK     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIN_MASK     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_NET_ID = 2'd2;

    localparam logic CMD_FRAME = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [FLAG_W-1:0]  SYN_MASK_RST     = 8'd1;
    localparam logic [FLAG_W-1:0]  FIN_MASK_RST     = 8'd2;
    localparam logic [NETID_W-1:0] FIRST_NET_ID_RST = 32'd1;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_SCAN = 5'b00010,
        ST_READ = 5'b00100,
        ST_UPD  = 5'b01000,
        ST_OUT  = 5'b10000
    } t_state;

    typedef struct packed {
        logic cap;
        logic scan_en;
        logic upd;
        logic out_load;
    } t_ctl_cmd;

    typedef struct packed {
        logic scan_done;
    } t_ctl_sts;

    typedef struct packed {
        logic                   handled;
        logic                   accepted;
        logic                   is_new;
        logic [SLOT_OUT_W-1:0]  slot;
        logic [PLAYER_W-1:0]    player;
        logic [NETID_W-1:0]     assigned;
        logic [NETID_W-1:0]     released;
        logic                   connected;
        logic [COUNT_OUT_W-1:0] count;
    } t_result;

endpackage

### hw/rtl/cst_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/cst_ctrl.sv
// Controller state machine: item handshakes and sequencing of scan, read and update.
module cst_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output cst_pkg::t_ctl_cmd o_cmd,
    input  cst_pkg::t_ctl_sts i_sts
);
    import cst_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_vld;
    logic   out_load;

    assign out_load = (r_state == ST_OUT) && (!r_out_vld || i_out_ready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: n_state = ST_UPD;
            ST_UPD:  n_state = ST_OUT;
            ST_OUT: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_in_ready     = (r_state == ST_IDLE);
    assign o_out_valid    = r_out_vld;
    assign o_cmd.cap      = (r_state == ST_IDLE) && i_in_valid;
    assign o_cmd.scan_en  = (r_state == ST_SCAN);
    assign o_cmd.upd      = (r_state == ST_UPD);
    assign o_cmd.out_load = out_load;

endmodule

### hw/rtl/cst_datapath.sv
// Datapath: slot and stack memories, scan compare, free-list counters and result registers.
module cst_datapath #(
    parameter int SLOTS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [cst_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [cst_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                               i_cmd,
    input  logic [cst_pkg::KEY_W-1:0]          i_peer_key,
    input  logic [cst_pkg::FLAG_W-1:0]         i_frame_flags,
    input  cst_pkg::t_ctl_cmd                  i_ctl,
    output cst_pkg::t_ctl_sts                  o_sts,
    output logic                               o_handled,
    output logic                               o_accepted,
    output logic                               o_is_new,
    output logic [cst_pkg::SLOT_OUT_W-1:0]     o_slot,
    output logic [cst_pkg::PLAYER_W-1:0]       o_player_number,
    output logic [cst_pkg::NETID_W-1:0]        o_assigned_net_id,
    output logic [cst_pkg::NETID_W-1:0]        o_released_net_id,
    output logic                               o_connected,
    output logic [cst_pkg::COUNT_OUT_W-1:0]    o_admitted_count
);
    import cst_pkg::*;

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS);
    localparam logic [CW-1:0] ONE_C   = CW'(1);

    logic [FLAG_W-1:0]   r_syn_mask;
    logic [FLAG_W-1:0]   r_fin_mask;
    logic                r_cmd;
    logic [KEY_W-1:0]    r_key;
    logic [FLAG_W-1:0]   r_flags;

    logic [CW-1:0]       r_scan_cnt;
    logic                r_cmp_vld;
    logic [SW-1:0]       r_cmp_idx;
    logic                r_hit;
    logic [SW-1:0]       r_hit_idx;
    logic                r_free;
    logic [SW-1:0]       r_free_idx;

    logic                r_valid [SLOTS];
    logic [CW-1:0]       r_occ;
    logic [CW-1:0]       r_icnt;
    logic [CW-1:0]       r_ncnt;
    logic [PLAYER_W-1:0] r_next_player;
    logic [NETID_W-1:0]  r_next_netid;

    logic [CW-1:0]       n_occ;
    logic [CW-1:0]       n_icnt;
    logic [CW-1:0]       n_ncnt;
    logic [PLAYER_W-1:0] n_next_player;
    logic [NETID_W-1:0]  n_next_netid;

    t_result             r_res;
    t_result             r_out;
    t_result             res;

    logic [KEY_W-1:0]    key_rd;
    logic [PLAYER_W-1:0] player_rd;
    logic [NETID_W-1:0]  netid_rd;
    logic [PLAYER_W-1:0] istk_rd;
    logic [NETID_W-1:0]  nstk_rd;

    logic [CW-1:0]       icnt_m1;
    logic [CW-1:0]       ncnt_m1;
    logic                scan_issue;
    logic                is_query;
    logic                fin_hit;
    logic                syn_hit;
    logic                do_rel;
    logic                do_syn;
    logic                do_new;
    logic                pop_player;
    logic                pop_net;
    logic [PLAYER_W-1:0] mint_player;
    logic [NETID_W-1:0]  mint_net;
    logic                push_net;
    logic                push_player;

    assign scan_issue = i_ctl.scan_en && (r_scan_cnt != SLOTS_C);
    assign o_sts.scan_done = (r_scan_cnt == SLOTS_C) && !r_cmp_vld;
    assign icnt_m1 = r_icnt - ONE_C;
    assign ncnt_m1 = r_ncnt - ONE_C;

    always_comb begin
        is_query    = (r_cmd == CMD_QUERY);
        fin_hit     = |(r_flags & r_fin_mask);
        syn_hit     = |(r_flags & r_syn_mask);
        do_rel      = !is_query && fin_hit && r_hit;
        do_syn      = !is_query && !fin_hit && syn_hit;
        do_new      = do_syn && !r_hit && r_free;
        pop_player  = (r_icnt != '0);
        pop_net     = (r_ncnt != '0);
        mint_player = pop_player ? istk_rd : r_next_player;
        mint_net    = pop_net ? nstk_rd : r_next_netid;
        push_net    = do_rel && (netid_rd != '0) && (r_ncnt != SLOTS_C);
        push_player = do_rel && (r_icnt != SLOTS_C);

        n_occ         = r_occ;
        n_icnt        = r_icnt;
        n_ncnt        = r_ncnt;
        n_next_player = r_next_player;
        n_next_netid  = r_next_netid;
        if (do_rel) begin
            if (r_occ != '0) begin
                n_occ = r_occ - ONE_C;
            end
            if (push_player) begin
                n_icnt = r_icnt + ONE_C;
            end
            if (push_net) begin
                n_ncnt = r_ncnt + ONE_C;
            end
        end else if (do_new) begin
            n_occ = r_occ + ONE_C;
            if (pop_player) begin
                n_icnt = icnt_m1;
            end else begin
                n_next_player = r_next_player + PLAYER_W'(1);
            end
            if (pop_net) begin
                n_ncnt = ncnt_m1;
            end else begin
                n_next_netid = r_next_netid + NETID_W'(1);
            end
        end

        res       = '0;
        res.count = COUNT_OUT_W'(n_occ);
        priority if (is_query) begin
            res.connected = r_hit;
            res.assigned  = r_hit ? netid_rd : '0;
        end else if (do_rel) begin
            res.handled  = 1'b1;
            res.released = netid_rd;
        end else if (do_syn) begin
            res.handled = 1'b1;
            if (r_hit) begin
                res.accepted = 1'b1;
                res.slot     = SLOT_OUT_W'(r_hit_idx);
                res.player   = player_rd;
                res.assigned = netid_rd;
            end else if (do_new) begin
                res.accepted = 1'b1;
                res.is_new   = 1'b1;
                res.slot     = SLOT_OUT_W'(r_free_idx);
                res.player   = mint_player;
                res.assigned = mint_net;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_syn_mask    <= SYN_MASK_RST;
            r_fin_mask    <= FIN_MASK_RST;
            r_next_netid  <= FIRST_NET_ID_RST;
            r_next_player <= '0;
            r_occ         <= '0;
            r_icnt        <= '0;
            r_ncnt        <= '0;
            for (int i = 0; i < SLOTS; i++) begin
                r_valid[i] <= 1'b0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_SYN_MASK:     r_syn_mask   <= i_cfg_data[FLAG_W-1:0];
                    CFG_FIN_MASK:     r_fin_mask   <= i_cfg_data[FLAG_W-1:0];
                    CFG_FIRST_NET_ID: r_next_netid <= i_cfg_data[NETID_W-1:0];
                    default: ;
                endcase
            end else if (i_ctl.upd) begin
                r_next_netid <= n_next_netid;
            end
            if (i_ctl.upd) begin
                r_next_player <= n_next_player;
                r_occ         <= n_occ;
                r_icnt        <= n_icnt;
                r_ncnt        <= n_ncnt;
                if (do_rel) begin
                    r_valid[r_hit_idx] <= 1'b0;
                end else if (do_new) begin
                    r_valid[r_free_idx] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_cnt <= '0;
            r_cmp_vld  <= 1'b0;
            r_hit      <= 1'b0;
            r_free     <= 1'b0;
        end else if (i_ctl.cap) begin
            r_scan_cnt <= '0;
            r_cmp_vld  <= 1'b0;
            r_hit      <= 1'b0;
            r_free     <= 1'b0;
        end else begin
            r_cmp_vld <= scan_issue;
            if (scan_issue) begin
                r_scan_cnt <= r_scan_cnt + ONE_C;
            end
            if (r_cmp_vld && r_valid[r_cmp_idx] && (key_rd == r_key) && !r_hit) begin
                r_hit <= 1'b1;
            end
            if (r_cmp_vld && !r_valid[r_cmp_idx] && !r_free) begin
                r_free <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.cap) begin
            r_cmd   <= i_cmd;
            r_key   <= i_peer_key;
            r_flags <= i_frame_flags;
        end
        r_cmp_idx <= r_scan_cnt[SW-1:0];
        if (r_cmp_vld && r_valid[r_cmp_idx] && (key_rd == r_key) && !r_hit) begin
            r_hit_idx <= r_cmp_idx;
        end
        if (r_cmp_vld && !r_valid[r_cmp_idx] && !r_free) begin
            r_free_idx <= r_cmp_idx;
        end
        if (i_ctl.upd) begin
            r_res <= res;
        end
        if (i_ctl.out_load) begin
            r_out <= r_res;
        end
    end

    cst_ram #(.WIDTH(KEY_W), .DEPTH(SLOTS)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (i_ctl.upd && do_new),
        .i_waddr (r_free_idx),
        .i_wdata (r_key),
        .i_raddr (r_scan_cnt[SW-1:0]),
        .o_rdata (key_rd)
    );

    cst_ram #(.WIDTH(PLAYER_W), .DEPTH(SLOTS)) u_player_ram (
        .i_clk   (i_clk),
        .i_we    (i_ctl.upd && do_new),
        .i_waddr (r_free_idx),
        .i_wdata (mint_player),
        .i_raddr (r_hit_idx),
        .o_rdata (player_rd)
    );

    cst_ram #(.WIDTH(NETID_W), .DEPTH(SLOTS)) u_netid_ram (
        .i_clk   (i_clk),
        .i_we    (i_ctl.upd && do_new),
        .i_waddr (r_free_idx),
        .i_wdata (mint_net),
        .i_raddr (r_hit_idx),
        .o_rdata (netid_rd)
    );

    cst_ram #(.WIDTH(PLAYER_W), .DEPTH(SLOTS)) u_index_stack (
        .i_clk   (i_clk),
        .i_we    (i_ctl.upd && push_player),
        .i_waddr (r_icnt[SW-1:0]),
        .i_wdata (player_rd),
        .i_raddr (icnt_m1[SW-1:0]),
        .o_rdata (istk_rd)
    );

    cst_ram #(.WIDTH(NETID_W), .DEPTH(SLOTS)) u_netid_stack (
        .i_clk   (i_clk),
        .i_we    (i_ctl.upd && push_net),
        .i_waddr (r_ncnt[SW-1:0]),
        .i_wdata (netid_rd),
        .i_raddr (ncnt_m1[SW-1:0]),
        .o_rdata (nstk_rd)
    );

    assign o_handled         = r_out.handled;
    assign o_accepted        = r_out.accepted;
    assign o_is_new          = r_out.is_new;
    assign o_slot            = r_out.slot;
    assign o_player_number   = r_out.player;
    assign o_assigned_net_id = r_out.assigned;
    assign o_released_net_id = r_out.released;
    assign o_connected       = r_out.connected;
    assign o_admitted_count  = r_out.count;

endmodule

### hw/rtl/connection_slot_table_unit.sv
// Top level of the connection slot table: controller, datapath and checks.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+------------------------------------------
//  input    | i_in_valid / o_in_ready   | i_cmd, i_peer_key, i_frame_flags
//  output   | o_out_valid / i_out_ready | o_handled .. o_admitted_count
//  config   | i_cfg_we                  | i_cfg_idx, i_cfg_data
//
//  An item runs through the scan, read, update and output states from accept to result;
//  the key memory is read once per slot in a linear scan.
//  Reset clears slot valid bits, stack counts and counters.
//  A finished result waits in the output register; the next item is taken
//  meanwhile, and only the hand-off of its own result waits on i_out_ready.
module connection_slot_table_unit #(
    parameter int SLOTS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [cst_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [cst_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic                               i_cmd,
    input  logic [cst_pkg::KEY_W-1:0]          i_peer_key,
    input  logic [cst_pkg::FLAG_W-1:0]         i_frame_flags,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic                               o_handled,
    output logic                               o_accepted,
    output logic                               o_is_new,
    output logic [cst_pkg::SLOT_OUT_W-1:0]     o_slot,
    output logic [cst_pkg::PLAYER_W-1:0]       o_player_number,
    output logic [cst_pkg::NETID_W-1:0]        o_assigned_net_id,
    output logic [cst_pkg::NETID_W-1:0]        o_released_net_id,
    output logic                               o_connected,
    output logic [cst_pkg::COUNT_OUT_W-1:0]    o_admitted_count
);
    import cst_pkg::*;

    t_ctl_cmd w_cmd;
    t_ctl_sts w_sts;

    cst_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    cst_datapath #(.SLOTS(SLOTS)) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_cmd             (i_cmd),
        .i_peer_key        (i_peer_key),
        .i_frame_flags     (i_frame_flags),
        .i_ctl             (w_cmd),
        .o_sts             (w_sts),
        .o_handled         (o_handled),
        .o_accepted        (o_accepted),
        .o_is_new          (o_is_new),
        .o_slot            (o_slot),
        .o_player_number   (o_player_number),
        .o_assigned_net_id (o_assigned_net_id),
        .o_released_net_id (o_released_net_id),
        .o_connected       (o_connected),
        .o_admitted_count  (o_admitted_count)
    );

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second item taken while one is in work");

    a_upd_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.upd |-> w_sts.scan_done)
        else $error("table update before scan finished");

    a_no_take_in_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.upd |-> (!o_in_ready && !w_cmd.out_load))
        else $error("update overlaps handshake");

endmodule
